/* design/mlfe_pkg.sv */
// ----------------------------------------------------------------------------
// mlfe_pkg: shared types and constants of the LCD framebuffer engine
// Screen geometry, command codes, display command bytes and the command
// bundle that runs from the controller to the datapath.
// ----------------------------------------------------------------------------
package mlfe_pkg;

    // Screen geometry
    localparam int SCREEN_COLS = 84;
    localparam int SCREEN_ROWS = 48;
    localparam int COL_W       = $clog2(SCREEN_COLS);
    localparam int NUM_BANKS   = (SCREEN_ROWS + 7) / 8;
    localparam int BANK_W      = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

    // Command codes on func
    localparam logic [2:0] FUNC_INIT    = 3'd0;
    localparam logic [2:0] FUNC_CLEAR   = 3'd1;
    localparam logic [2:0] FUNC_RECT    = 3'd2;
    localparam logic [2:0] FUNC_LINES   = 3'd3;
    localparam logic [2:0] FUNC_CHECKER = 3'd4;
    localparam logic [2:0] FUNC_FLUSH   = 3'd5;

    // Beat kinds within one flush bank
    localparam logic [1:0] PH_XADDR = 2'd0;
    localparam logic [1:0] PH_YADDR = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;

    // Init sequence steps
    localparam logic [2:0] INIT_STEP_EXT   = 3'd0;
    localparam logic [2:0] INIT_STEP_VOP   = 3'd1;
    localparam logic [2:0] INIT_STEP_TEMP  = 3'd2;
    localparam logic [2:0] INIT_STEP_BIAS  = 3'd3;
    localparam logic [2:0] INIT_STEP_BASIC = 3'd4;
    localparam logic [2:0] INIT_STEP_DISP  = 3'd5;

    // Display command bytes
    localparam logic [7:0] CMD_EXT_SET   = 8'h21;
    localparam logic [7:0] CMD_BASIC_SET = 8'h20;
    localparam logic [7:0] CMD_DISP_NORM = 8'h0C;
    localparam logic [7:0] CMD_SET_X     = 8'h80;
    localparam logic [7:0] CMD_SET_Y     = 8'h40;

    // Configuration registers
    localparam int         ADDR_W     = 4;
    localparam logic [1:0] REG_VOP    = 2'd0;
    localparam logic [1:0] REG_TEMP   = 2'd1;
    localparam logic [1:0] REG_BIAS   = 2'd2;
    localparam logic [7:0] VOP_RESET  = 8'hB0;
    localparam logic [7:0] TEMP_RESET = 8'h04;
    localparam logic [7:0] BIAS_RESET = 8'h14;

    // Row patterns
    localparam logic [SCREEN_ROWS-1:0] FULL_WORD = '1;
    localparam logic [63:0] PAT_EVEN_64 = 64'h5555_5555_5555_5555;
    localparam logic [63:0] PAT_ODD_64  = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [SCREEN_ROWS-1:0] PAT_EVEN = PAT_EVEN_64[SCREEN_ROWS-1:0];
    localparam logic [SCREEN_ROWS-1:0] PAT_ODD  = PAT_ODD_64[SCREEN_ROWS-1:0];

    typedef struct packed {
        logic [7:0] vop;
        logic [7:0] temp;
        logic [7:0] bias;
    } mlfe_cfg_t;

    typedef struct packed {
        logic              load;
        logic              rd_en;
        logic              sweep;
        logic [COL_W-1:0]  col;
        logic              col_six;
        logic              emit_init;
        logic              emit_flush;
        logic [2:0]        init_step;
        logic [BANK_W-1:0] bank;
        logic [1:0]        phase;
    } mlfe_cmd_t;

endpackage

/* design/mono_lcd_framebuffer_engine.sv */
// ----------------------------------------------------------------------------
// mono_lcd_framebuffer_engine: monochrome LCD framebuffer and command engine
// Keeps an 84 x 48 one-bit image and turns commands into display byte beats.
// ----------------------------------------------------------------------------
// One command is taken at a time. After reset a clearing pass writes every
// column of the image memory and holds in_ready low until it ends. Clear,
// rectangle, test lines and checkerboard each sweep all 84 columns through
// one read-modify-write pipeline on the column memory, and in_ready stays
// low until the sweep is done. Init sends 6 beats and a flush sends 18 beats
// (address, bank and data per bank of 8 rows), one beat per cycle while
// out_ready stays high; a flush first reads its column in a setup state.
// A flush of a column beyond the screen, and func codes 6 and 7, send nothing.
// Configuration registers sit at byte addresses 0, 4, 8.
// ----------------------------------------------------------------------------
module mono_lcd_framebuffer_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mlfe_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  func,
    input  logic [6:0]                  x_pos,
    input  logic [5:0]                  y_pos,
    input  logic [5:0]                  rect_height,
    input  logic [6:0]                  rect_width,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_byte,
    output logic                        is_data,
    output logic                        last
);

    mlfe_pkg::mlfe_cfg_t cfg;
    mlfe_pkg::mlfe_cmd_t cmd;
    logic                flush_ok;

    mlfe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mlfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .flush_ok  (flush_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    mlfe_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg         (cfg),
        .func        (func),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .rect_height (rect_height),
        .rect_width  (rect_width),
        .flush_ok    (flush_ok),
        .out_byte    (out_byte),
        .is_data     (is_data),
        .last        (last)
    );

endmodule

/* design/mlfe_regs.sv */
// ----------------------------------------------------------------------------
// mlfe_regs: configuration register file
// APB-style write and read of the three init command bytes.
// ----------------------------------------------------------------------------
module mlfe_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mlfe_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output mlfe_pkg::mlfe_cfg_t        cfg
);

    mlfe_pkg::mlfe_cfg_t cfg_reg;
    logic [1:0]          idx;
    logic                wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    // Take register writes in the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vop  <= mlfe_pkg::VOP_RESET;
            cfg_reg.temp <= mlfe_pkg::TEMP_RESET;
            cfg_reg.bias <= mlfe_pkg::BIAS_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                mlfe_pkg::REG_VOP:  cfg_reg.vop  <= pwdata[7:0];
                mlfe_pkg::REG_TEMP: cfg_reg.temp <= pwdata[7:0];
                mlfe_pkg::REG_BIAS: cfg_reg.bias <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        unique case (idx)
            mlfe_pkg::REG_VOP:  prdata = {24'd0, cfg_reg.vop};
            mlfe_pkg::REG_TEMP: prdata = {24'd0, cfg_reg.temp};
            mlfe_pkg::REG_BIAS: prdata = {24'd0, cfg_reg.bias};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

/* design/mlfe_ctrl.sv */
// ----------------------------------------------------------------------------
// mlfe_ctrl: command sequencer
// Accepts one command at a time, walks the column sweep, the flush beats
// and the init beats, and drives the datapath by a command bundle.
// ----------------------------------------------------------------------------
module mlfe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           func,
    input  logic                 flush_ok,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mlfe_pkg::mlfe_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_TAIL,
        ST_FLUSH_RD,
        ST_EMIT_FLUSH,
        ST_EMIT_INIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [mlfe_pkg::COL_W-1:0]    col_reg, col_next;
    logic [2:0]                    six_reg, six_next;
    logic [2:0]                    step_reg, step_next;
    logic [mlfe_pkg::BANK_W-1:0]   bank_reg, bank_next;
    logic [1:0]                    phase_reg, phase_next;
    logic                          in_ready_reg, in_ready_next;
    logic                          out_valid_reg, out_valid_next;

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    // Drive the datapath from the current state
    always_comb
    begin
        cmd            = '0;
        cmd.load       = in_valid & in_ready_reg;
        cmd.rd_en      = (state_reg == ST_SWEEP) || (state_reg == ST_FLUSH_RD);
        cmd.sweep      = (state_reg == ST_SWEEP);
        cmd.col        = col_reg;
        cmd.col_six    = (six_reg == 3'd0);
        cmd.emit_init  = (state_reg == ST_EMIT_INIT);
        cmd.emit_flush = (state_reg == ST_EMIT_FLUSH);
        cmd.init_step  = step_reg;
        cmd.bank       = bank_reg;
        cmd.phase      = phase_reg;
    end

    // Next state and counters
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        six_next       = six_reg;
        step_next      = step_reg;
        bank_next      = bank_reg;
        phase_next     = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    col_next   = '0;
                    six_next   = 3'd0;
                    step_next  = mlfe_pkg::INIT_STEP_EXT;
                    bank_next  = '0;
                    phase_next = mlfe_pkg::PH_XADDR;
                    unique case (func)
                        mlfe_pkg::FUNC_INIT:    state_next = ST_EMIT_INIT;
                        mlfe_pkg::FUNC_CLEAR,
                        mlfe_pkg::FUNC_RECT,
                        mlfe_pkg::FUNC_LINES,
                        mlfe_pkg::FUNC_CHECKER: state_next = ST_SWEEP;
                        mlfe_pkg::FUNC_FLUSH:
                            state_next = flush_ok ? ST_FLUSH_RD : ST_IDLE;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SWEEP:
            begin
                // Advance the column and its modulo-six phase
                col_next = col_reg + 1'b1;
                six_next = (six_reg == 3'd5) ? 3'd0 : six_reg + 3'd1;
                if (col_reg == mlfe_pkg::COL_W'(mlfe_pkg::SCREEN_COLS - 1))
                    state_next = ST_TAIL;
            end
            ST_TAIL:
            begin
                state_next = ST_IDLE;
            end
            ST_FLUSH_RD:
            begin
                state_next = ST_EMIT_FLUSH;
            end
            ST_EMIT_FLUSH:
            begin
                if (out_ready)
                begin
                    if (phase_reg == mlfe_pkg::PH_DATA)
                    begin
                        phase_next = mlfe_pkg::PH_XADDR;
                        if (bank_reg == mlfe_pkg::BANK_W'(mlfe_pkg::NUM_BANKS - 1))
                            state_next = ST_IDLE;
                        else
                            bank_next = bank_reg + 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
            end
            ST_EMIT_INIT:
            begin
                if (out_ready)
                begin
                    if (step_reg == mlfe_pkg::INIT_STEP_DISP)
                        state_next = ST_IDLE;
                    else
                        step_next = step_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        in_ready_next  = (state_next == ST_IDLE);
        out_valid_next = (state_next == ST_EMIT_FLUSH) || (state_next == ST_EMIT_INIT);
    end

    // Hold state and registered handshake outputs; start with the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            col_reg       <= '0;
            six_reg       <= 3'd0;
            step_reg      <= 3'd0;
            bank_reg      <= '0;
            phase_reg     <= mlfe_pkg::PH_XADDR;
            in_ready_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            six_reg       <= six_next;
            step_reg      <= step_next;
            bank_reg      <= bank_next;
            phase_reg     <= phase_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* design/mlfe_dp.sv */
// ----------------------------------------------------------------------------
// mlfe_dp: framebuffer datapath
// Column memory with a read-modify-write stage for the drawing commands,
// the command operand registers and the output beat formatter.
// ----------------------------------------------------------------------------
module mlfe_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  mlfe_pkg::mlfe_cmd_t cmd,
    input  mlfe_pkg::mlfe_cfg_t cfg,
    input  logic [2:0]          func,
    input  logic [6:0]          x_pos,
    input  logic [5:0]          y_pos,
    input  logic [5:0]          rect_height,
    input  logic [6:0]          rect_width,
    output logic                flush_ok,
    output logic [7:0]          out_byte,
    output logic                is_data,
    output logic                last
);

    localparam int ROWS   = mlfe_pkg::SCREEN_ROWS;
    localparam int PADDED = mlfe_pkg::NUM_BANKS * 8;

    logic [ROWS-1:0]            mem [mlfe_pkg::SCREEN_COLS];
    logic [ROWS-1:0]            rd_data_reg;
    logic                       wr_pend_reg;
    logic [mlfe_pkg::COL_W-1:0] wr_col_reg;
    logic                       six_d_reg;
    logic [2:0]                 op_reg;
    logic [6:0]                 x_reg;
    logic [7:0]                 x_end_reg;
    logic                       rect_ok_reg;
    logic [ROWS-1:0]            mask_reg;

    logic [7:0]                 x_end;
    logic [6:0]                 y_end;
    logic                       rect_ok;
    logic [ROWS-1:0]            mask;
    logic [mlfe_pkg::COL_W-1:0] rd_addr;
    logic                       in_rect;
    logic [ROWS-1:0]            new_word;
    logic [PADDED-1:0]          word_pad;
    logic [7:0]                 init_byte;

    assign flush_ok = ({1'b0, x_pos} < 8'(mlfe_pkg::SCREEN_COLS));

    // Decode the rectangle at accept
    assign x_end   = 8'(x_pos) + 8'(rect_width);
    assign y_end   = 7'(y_pos) + 7'(rect_height);
    assign rect_ok = (x_end <= 8'(mlfe_pkg::SCREEN_COLS))
                   && (y_end <= 7'(ROWS))
                   && (rect_width != 7'd0) && (rect_height != 6'd0);

    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
            mask[r] = (7'(r) >= {1'b0, y_pos}) && (7'(r) < y_end);
    end

    // Capture command operands
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg       <= x_pos;
            x_end_reg   <= x_end;
            rect_ok_reg <= rect_ok;
            mask_reg    <= mask;
        end
    end

    // Hold the op code; reset selects the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_reg <= mlfe_pkg::FUNC_CLEAR;
        else if (cmd.load)
            op_reg <= func;
    end

    // Select the read column: sweep counter or flush column
    assign rd_addr = cmd.sweep ? cmd.col : x_reg[mlfe_pkg::COL_W-1:0];

    // Modify the column read in the previous cycle
    assign in_rect = rect_ok_reg
                   && (8'(wr_col_reg) >= {1'b0, x_reg})
                   && (8'(wr_col_reg) < x_end_reg);

    always_comb
    begin
        unique case (op_reg)
            mlfe_pkg::FUNC_CLEAR:   new_word = '0;
            mlfe_pkg::FUNC_RECT:    new_word = in_rect ? (rd_data_reg | mask_reg)
                                                       : rd_data_reg;
            mlfe_pkg::FUNC_LINES:   new_word = six_d_reg ? mlfe_pkg::FULL_WORD
                                                         : rd_data_reg;
            mlfe_pkg::FUNC_CHECKER: new_word = rd_data_reg
                                             | (wr_col_reg[0] ? mlfe_pkg::PAT_ODD
                                                              : mlfe_pkg::PAT_EVEN);
            default:                new_word = rd_data_reg;
        endcase
    end

    // Column memory: one registered read port, one write port
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
        if (wr_pend_reg)
            mem[wr_col_reg] <= new_word;
    end

    always_ff @(posedge clk)
    begin
        wr_col_reg <= rd_addr;
        six_d_reg  <= cmd.col_six;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_pend_reg <= 1'b0;
        else
            wr_pend_reg <= cmd.rd_en & cmd.sweep;
    end

    // Format the output beat
    assign word_pad = PADDED'(rd_data_reg);

    always_comb
    begin
        unique case (cmd.init_step)
            mlfe_pkg::INIT_STEP_EXT:   init_byte = mlfe_pkg::CMD_EXT_SET;
            mlfe_pkg::INIT_STEP_VOP:   init_byte = cfg.vop;
            mlfe_pkg::INIT_STEP_TEMP:  init_byte = cfg.temp;
            mlfe_pkg::INIT_STEP_BIAS:  init_byte = cfg.bias;
            mlfe_pkg::INIT_STEP_BASIC: init_byte = mlfe_pkg::CMD_BASIC_SET;
            mlfe_pkg::INIT_STEP_DISP:  init_byte = mlfe_pkg::CMD_DISP_NORM;
            default:                   init_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        out_byte = 8'd0;
        is_data  = 1'b0;
        last     = 1'b0;
        if (cmd.emit_init)
        begin
            out_byte = init_byte;
            last     = (cmd.init_step == mlfe_pkg::INIT_STEP_DISP);
        end
        else if (cmd.emit_flush)
        begin
            unique case (cmd.phase)
                mlfe_pkg::PH_XADDR: out_byte = mlfe_pkg::CMD_SET_X | 8'(x_reg);
                mlfe_pkg::PH_YADDR: out_byte = mlfe_pkg::CMD_SET_Y | 8'(cmd.bank);
                mlfe_pkg::PH_DATA:
                begin
                    out_byte = word_pad[{cmd.bank, 3'b000} +: 8];
                    is_data  = 1'b1;
                    last     = (cmd.bank == mlfe_pkg::BANK_W'(mlfe_pkg::NUM_BANKS - 1));
                end
                default: out_byte = 8'd0;
            endcase
        end
    end

endmodule
